// ----- sv/nearest_reference_match_macros.svh -----
// Assertion macros shared by the nearest reference match RTL.
// Depends on nothing; each use site must have i_clk and i_rst_n in scope.
`ifndef NEAREST_REFERENCE_MATCH_MACROS_SVH
`define NEAREST_REFERENCE_MATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define NRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define NRM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/nrm_pkg.sv -----
// Package for the nearest reference match block: widths, library tables,
// recipe scale table, sequencer states and the divider request/response types.
package nrm_pkg;

    localparam int TIME_W      = 16;
    localparam int SKEW_W      = 16;
    localparam int IDX_W       = 6;
    localparam int LIB_ENTRIES = 41;
    localparam int BUILTIN     = 41;
    localparam int RECIPE_W    = 8;
    localparam int TOL_W       = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;
    localparam int RECIPES     = 8;

    // Shared multiplier operand and product widths
    localparam int MA_W = 32;
    localparam int MB_W = 24;
    localparam int MP_W = MA_W + MB_W;

    // Time error quotient width (Q8.16) and distance width
    localparam int E_W    = 24;
    localparam int DIST_W = 64;
    localparam int S_W    = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RECIPE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b1;

    localparam logic [RECIPE_W-1:0] RECIPE_RST = 8'd0;
    localparam logic [TOL_W-1:0]    TOL_RST    = 15'd1280;

    // Weights 0.8 and 0.2 in Q0.16; skew weight carries the Q2.13 to Q8.16 step
    localparam logic [MB_W-1:0] WEIGHT_TIME  = 24'd52429;
    localparam logic [MB_W-1:0] WEIGHT_SKEW  = 24'd838848;
    localparam logic [MB_W-1:0] PCT_SCALE    = 24'd25600;
    localparam logic [15:0]     SCALE_ONE    = 16'd32768;

    localparam logic [15:0] SCALE_Q15 [RECIPES] = '{
        16'd32768, 16'd31130, 16'd34406, 16'd32113,
        16'd36045, 16'd39322, 16'd33423, 16'd30147
    };

    // Library migration times in whole seconds
    localparam logic [9:0] LIB_SEC [BUILTIN] = '{
        10'd65,  10'd68,  10'd72,  10'd80,  10'd95,  10'd102, 10'd108, 10'd118,
        10'd122, 10'd125, 10'd128, 10'd130, 10'd135, 10'd138, 10'd155, 10'd160,
        10'd165, 10'd175, 10'd180, 10'd185, 10'd190, 10'd205, 10'd215, 10'd210,
        10'd208, 10'd200, 10'd198, 10'd225, 10'd235, 10'd245, 10'd250, 10'd255,
        10'd270, 10'd280, 10'd290, 10'd285, 10'd275, 10'd310, 10'd300, 10'd330,
        10'd260
    };

    // Library skewness values, Q2.13
    localparam logic signed [SKEW_W-1:0] LIB_SKEW [BUILTIN] = '{
        16'sd819,   16'sd655,   16'sd983,   16'sd1229,  16'sd1638,  16'sd1638,
        16'sd1802,  16'sd2048,  16'sd1802,  16'sd1884,  16'sd1802,  16'sd1802,
        16'sd2048,  16'sd1884,  16'sd2458,  16'sd2294,  16'sd2458,  16'sd2867,
        16'sd2867,  16'sd3277,  16'sd0,     -16'sd819,  -16'sd983,  -16'sd819,
        -16'sd655,  -16'sd819,  -16'sd655,  -16'sd1229, -16'sd1475, -16'sd1638,
        -16'sd1638, -16'sd1802, -16'sd2048, -16'sd2048, -16'sd2294, -16'sd2048,
        -16'sd1802, -16'sd2458, -16'sd2048, -16'sd2867, -16'sd1638
    };

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCALE,
        ST_DIFF,
        ST_DWAIT,
        ST_M_EE,
        ST_M_E2L,
        ST_M_E2H,
        ST_M_AA,
        ST_M_A2L,
        ST_M_A2H,
        ST_ACC,
        ST_CMP,
        ST_TOL1,
        ST_TOL2,
        ST_TOL3,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic           start;
        logic [S_W-1:0] num;
        logic [S_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [E_W-1:0] quot;
    } t_div_rsp;

    // Library time in Q10.6; entries past the built-in set read as zero
    function automatic logic [TIME_W-1:0] lib_time(input logic [IDX_W-1:0] idx);
        logic [TIME_W-1:0] v;
        v = '0;
        if (idx < IDX_W'(BUILTIN)) begin
            v = {LIB_SEC[idx], 6'b0};
        end
        return v;
    endfunction

    function automatic logic signed [SKEW_W-1:0] lib_skew(input logic [IDX_W-1:0] idx);
        logic signed [SKEW_W-1:0] v;
        v = '0;
        if (idx < IDX_W'(BUILTIN)) begin
            v = LIB_SKEW[idx];
        end
        return v;
    endfunction

    // Recipe scale in Q1.15; unknown recipes use 1.0
    function automatic logic [15:0] scale_of(input logic [RECIPE_W-1:0] recipe);
        logic [15:0] v;
        v = SCALE_ONE;
        if (recipe < RECIPE_W'(RECIPES)) begin
            v = SCALE_Q15[recipe[2:0]];
        end
        return v;
    endfunction

endpackage

// ----- sv/nrm_peak_if.sv -----
// Peak input channel: valid/ready handshake carrying time and skewness.
// Depends on nrm_pkg for field widths.
interface nrm_peak_if
    import nrm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        peak_time;
    logic signed [SKEW_W-1:0] peak_skew;

    modport source (output valid, output peak_time, output peak_skew, input ready);
    modport sink   (input valid, input peak_time, input peak_skew, output ready);
endinterface

// ----- sv/nrm_match_if.sv -----
// Match result channel: valid/ready handshake carrying index and match flag.
// Depends on nrm_pkg for field widths.
interface nrm_match_if
    import nrm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] ion_index;
    logic             matched;

    modport source (output valid, output ion_index, output matched, input ready);
    modport sink   (input valid, input ion_index, input matched, output ready);
endinterface

// ----- sv/nrm_mul.sv -----
// Shared multiplier of the match sequencer: 32 x 24 bits, product registered.
// Depends on nrm_pkg for operand widths.
module nrm_mul
    import nrm_pkg::*;
(
    input  logic            i_clk,
    input  logic [MA_W-1:0] i_a,
    input  logic [MB_W-1:0] i_b,
    output logic [MP_W-1:0] o_prod
);

    logic [MP_W-1:0] r_prod;

    // Register the product; one multiply per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= {{MB_W{1'b0}}, i_a} * {{MA_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

// ----- sv/nrm_div.sv -----
// Restoring divider for the relative time error: floor(num * 2^16 / den),
// one quotient bit a cycle, saturated to all ones. Depends on nrm_pkg.
module nrm_div
    import nrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [4:0] DIV_STEPS = 5'(E_W);

    logic           r_busy;
    logic           r_done;
    logic [4:0]     r_cnt;
    logic [S_W-1:0] r_rem;
    logic [S_W-1:0] r_den;
    logic [E_W-1:0] r_low;
    logic [E_W-1:0] r_quot;

    logic [S_W:0]   trial;
    logic [S_W:0]   trial_sub;
    logic           trial_ge;
    logic           sat_c;

    // Trial subtract of the shifted remainder
    always_comb begin
        trial     = {r_rem, r_low[E_W-1]};
        trial_sub = trial - {1'b0, r_den};
        trial_ge  = (trial >= {1'b0, r_den});
        sat_c     = ({8'b0, i_req.num} >= {i_req.den, 8'b0});
    end

    // Control: step count, busy and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (sat_c) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= DIV_STEPS;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load the dividend, then shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= {8'b0, i_req.num[S_W-1:8]};
            r_low  <= {i_req.num[7:0], 16'b0};
            r_den  <= i_req.den;
            r_quot <= '1;
        end else if (r_busy) begin
            r_rem  <= trial_ge ? trial_sub[S_W-1:0] : trial[S_W-1:0];
            r_low  <= {r_low[E_W-2:0], 1'b0};
            r_quot <= {r_quot[E_W-2:0], trial_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- sv/nearest_reference_match.sv -----
// Nearest reference match: a peak beat on i_peak (time Q10.6, skew Q2.13)
// is compared against the 41-entry built-in library, scanned one entry at a
// time by a sequencer around one shared 32x24 multiplier and a radix-2
// divider. The weighted distance 0.8*e^2 + 0.2*ds^2 is kept at its minimum,
// the lower index winning ties; the winner is then checked against the
// tolerance register. One result beat on o_match follows each peak beat.
// Each entry passes through the load, scale and diff setup states, the divider
// wait (cut short when its time error saturates) and 8 multiply, accumulate
// and compare steps. i_peak.ready is high only while the sequencer is idle,
// so a new peak is taken only after the previous one has been scanned and
// its result moved to the output register.
// The result sits in an output register; a new peak is accepted while it
// waits. If o_match is still stalled when the next result is done, the
// sequencer holds in its final state until the register frees.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 recipe, 1 tolerance_pct); write only while idle.
// Reset (synchronous, active low) returns recipe 0, tolerance 1280 and
// empties the output register.
`include "nearest_reference_match_macros.svh"

module nearest_reference_match
    import nrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nrm_peak_if.sink              i_peak,
    nrm_match_if.source           o_match,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state;
    t_state n_state;

    // Configuration registers
    logic [RECIPE_W-1:0] r_recipe;
    logic [TOL_W-1:0]    r_tol;

    // Per-item and per-entry working registers
    logic [TIME_W-1:0]        r_time;
    logic signed [SKEW_W-1:0] r_skew;
    logic [IDX_W-1:0]         r_idx;
    logic [TIME_W-1:0]        r_ref_time;
    logic [SKEW_W-1:0]        r_ads;
    logic [S_W-1:0]           r_s;
    logic [S_W-1:0]           r_diff;
    logic [E_W-1:0]           r_e;
    logic [MB_W-1:0]          r_e2hi;
    logic [7:0]               r_a2hi;
    logic [DIST_W-1:0]        r_dist;

    // Best entry so far
    logic [DIST_W-1:0]        r_best_dist;
    logic [IDX_W-1:0]         r_best_idx;
    logic [S_W-1:0]           r_best_diff;
    logic [S_W-1:0]           r_best_s;
    logic [46:0]              r_lhs;
    logic                     r_ok;

    // Output register
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_index;
    logic                     r_out_match;

    // Combinational controls
    logic                     in_fire;
    logic                     out_free;
    logic                     last_entry;
    logic [MA_W-1:0]          mul_a;
    logic [MB_W-1:0]          mul_b;
    logic [MP_W-1:0]          mul_p;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;
    logic [S_W-1:0]           s_c;
    logic [S_W-1:0]           t_c;
    logic [S_W-1:0]           diff_c;
    logic signed [SKEW_W-1:0] ref_skew_c;
    logic [SKEW_W:0]          ds_c;
    logic [SKEW_W:0]          ads_c;

    nrm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    nrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_fire    = i_peak.valid && i_peak.ready;
    assign out_free   = !r_out_valid || o_match.ready;
    assign last_entry = (r_idx == IDX_W'(LIB_ENTRIES - 1));

    // Scaled reference, absolute time difference and skew difference
    always_comb begin
        s_c        = mul_p[S_W-1:0];
        t_c        = {1'b0, r_time, 15'b0};
        diff_c     = (t_c > s_c) ? (t_c - s_c) : (s_c - t_c);
        ref_skew_c = lib_skew(r_idx);
        ds_c       = {r_skew[SKEW_W-1], r_skew} -
                     {ref_skew_c[SKEW_W-1], ref_skew_c};
        ads_c      = ds_c[SKEW_W] ? ((SKEW_W + 1)'(0) - ds_c) : ds_c;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_DWAIT;
            ST_DWAIT: if (div_rsp.done) n_state = ST_M_EE;
            ST_M_EE:  n_state = ST_M_E2L;
            ST_M_E2L: n_state = ST_M_E2H;
            ST_M_E2H: n_state = ST_M_AA;
            ST_M_AA:  n_state = ST_M_A2L;
            ST_M_A2L: n_state = ST_M_A2H;
            ST_M_A2H: n_state = ST_ACC;
            ST_ACC:   n_state = ST_CMP;
            ST_CMP:   n_state = last_entry ? ST_TOL1 : ST_LOAD;
            ST_TOL1:  n_state = ST_TOL2;
            ST_TOL2:  n_state = ST_TOL3;
            ST_TOL3:  n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready, multiplier operands, divider start
    always_comb begin
        i_peak.ready  = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.num   = diff_c;
        div_req.den   = s_c;
        unique case (r_state)
            ST_IDLE:  i_peak.ready = 1'b1;
            ST_SCALE: begin
                mul_a = {{(MA_W - TIME_W){1'b0}}, r_ref_time};
                mul_b = {8'b0, scale_of(r_recipe)};
            end
            ST_DIFF:  div_req.start = 1'b1;
            ST_M_EE: begin
                mul_a = {{(MA_W - E_W){1'b0}}, r_e};
                mul_b = r_e;
            end
            ST_M_E2L: begin
                mul_a = {{(MA_W - MB_W){1'b0}}, mul_p[MB_W-1:0]};
                mul_b = WEIGHT_TIME;
            end
            ST_M_E2H: begin
                mul_a = {{(MA_W - MB_W){1'b0}}, r_e2hi};
                mul_b = WEIGHT_TIME;
            end
            ST_M_AA: begin
                mul_a = {{(MA_W - SKEW_W){1'b0}}, r_ads};
                mul_b = {{(MB_W - SKEW_W){1'b0}}, r_ads};
            end
            ST_M_A2L: begin
                mul_a = {{(MA_W - MB_W){1'b0}}, mul_p[MB_W-1:0]};
                mul_b = WEIGHT_SKEW;
            end
            ST_M_A2H: begin
                mul_a = {24'b0, r_a2hi};
                mul_b = WEIGHT_SKEW;
            end
            ST_TOL1: begin
                mul_a = r_best_diff;
                mul_b = PCT_SCALE;
            end
            ST_TOL2: begin
                mul_a = r_best_s;
                mul_b = {{(MB_W - TOL_W){1'b0}}, r_tol};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // State, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_recipe    <= RECIPE_RST;
            r_tol       <= TOL_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RECIPE:    r_recipe <= i_cfg_data[RECIPE_W-1:0];
                    CFG_TOLERANCE: r_tol    <= i_cfg_data[TOL_W-1:0];
                endcase
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_match.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: latch the peak, walk the entries, accumulate and keep the best
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_time <= i_peak.peak_time;
                    r_skew <= i_peak.peak_skew;
                    r_idx  <= '0;
                end
            end
            ST_LOAD: begin
                r_ref_time <= lib_time(r_idx);
                r_ads      <= ads_c[SKEW_W-1:0];
            end
            ST_DIFF: begin
                r_s    <= s_c;
                r_diff <= diff_c;
            end
            ST_DWAIT: if (div_rsp.done) r_e <= div_rsp.quot;
            ST_M_E2L: r_e2hi <= mul_p[2*E_W-1:MB_W];
            ST_M_E2H: r_dist <= {{(DIST_W - 40){1'b0}}, mul_p[39:0]};
            ST_M_AA:  r_dist <= r_dist + {mul_p[39:0], 24'b0};
            ST_M_A2L: r_a2hi <= mul_p[31:24];
            ST_M_A2H: r_dist <= r_dist + {20'b0, mul_p[43:0]};
            ST_ACC:   r_dist <= r_dist + {8'b0, mul_p[31:0], 24'b0};
            ST_CMP: begin
                if (r_idx == '0 || r_dist < r_best_dist) begin
                    r_best_dist <= r_dist;
                    r_best_idx  <= r_idx;
                    r_best_diff <= r_diff;
                    r_best_s    <= r_s;
                end
                if (!last_entry) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            ST_TOL2: r_lhs <= mul_p[46:0];
            ST_TOL3: r_ok  <= !(r_lhs > mul_p[46:0]);
            ST_OUT: begin
                if (out_free) begin
                    r_out_index <= r_ok ? r_best_idx : '0;
                    r_out_match <= r_ok;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_match.valid     = r_out_valid;
    assign o_match.ion_index = r_out_index;
    assign o_match.matched   = r_out_match;

    // Checks on the sequencer
    `NRM_ASSERT_NXT(a_accept_starts_scan, in_fire, r_state == ST_LOAD && r_idx == '0,
        "accepted peak did not start the scan at entry zero")
    `NRM_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, r_state == ST_DWAIT,
        "divider finished outside the wait state")
    `NRM_ASSERT_IMP(a_idx_in_range, r_state != ST_IDLE, r_idx <= IDX_W'(LIB_ENTRIES - 1),
        "entry index ran past the library")
    `NRM_ASSERT_IMP(a_unmatched_zero, r_out_valid && !r_out_match, r_out_index == '0,
        "unmatched result carries a nonzero index")

endmodule
